@@ rtl/nlp_pkg.sv @@
// ============================================================================
// nlp_pkg
// Shared types and constants for the next-permutation engine: element width,
// default store depth, write-data select codes and controller/datapath links.
// ============================================================================
`default_nettype none

package nlp_pkg;

    // Element width and default store capacity.
    localparam int DATA_W      = 16;
    localparam int MAX_LEN_DEF = 16;

    // Write-data select for the element store.
    localparam logic [1:0] WSEL_IN    = 2'd0;  // incoming stream element
    localparam logic [1:0] WSEL_PIV   = 2'd1;  // saved pivot value
    localparam logic [1:0] WSEL_HOLD  = 2'd2;  // holding register
    localparam logic [1:0] WSEL_RDATA = 2'd3;  // registered read data

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       mem_we;     // write the element store
        logic [1:0] wsel;       // source of the write data
        logic       prev_ld;    // capture read data as the right neighbor
        logic       piv_ld;     // capture read data as the pivot value
        logic       hold_ld;    // capture read data into the holding register
        logic       out_ld;     // load the output register
        logic       out_last;   // end of run flag for the loaded result
        logic       out_found;  // next permutation flag for the loaded result
        logic       out_ovf;    // overflow flag for the loaded result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lt_prev;   // read data is less than its right neighbor
        logic gt_piv;    // read data is greater than the pivot value
        logic out_free;  // output register can take a new result this cycle
    } t_status;

endpackage

`default_nettype wire

@@ rtl/nlp_datapath.sv @@
// ============================================================================
// nlp_datapath
// Element store, read-data register, compare logic and the output register
// that holds one result transaction for the master side.
// ============================================================================
`default_nettype none

module nlp_datapath
    import nlp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    localparam int IW     = $clog2(MAX_LEN)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [IW-1:0]     i_waddr,
    input  wire logic [IW-1:0]     i_raddr,
    input  wire logic [DATA_W-1:0] i_in_data,
    output t_status                o_status,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [DATA_W-1:0]      o_out_data,
    output logic                   o_out_last,
    output logic                   o_out_found,
    output logic                   o_out_ovf
);

    logic [DATA_W-1:0] r_mem [MAX_LEN];
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] r_prev;
    logic [DATA_W-1:0] r_piv;
    logic [DATA_W-1:0] r_hold;
    logic [DATA_W-1:0] n_wdata;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;
    logic              r_out_found;
    logic              r_out_ovf;

    // Write data select.
    always_comb begin
        case (i_cmd.wsel)
            WSEL_IN:    n_wdata = i_in_data;
            WSEL_PIV:   n_wdata = r_piv;
            WSEL_HOLD:  n_wdata = r_hold;
            default:    n_wdata = r_rdata;
        endcase
    end

    // Element store with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[i_waddr] <= n_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // Working registers loaded from the read data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.prev_ld) begin
            r_prev <= r_rdata;
        end
        if (i_cmd.piv_ld) begin
            r_piv <= r_rdata;
        end
        if (i_cmd.hold_ld) begin
            r_hold <= r_rdata;
        end
    end

    // Signed compares used by the pivot and successor searches.
    assign o_status.lt_prev  = $signed(r_rdata) < $signed(r_prev);
    assign o_status.gt_piv   = $signed(r_rdata) > $signed(r_piv);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Output register: valid flag under reset, payload without.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_data  <= r_rdata;
            r_out_last  <= i_cmd.out_last;
            r_out_found <= i_cmd.out_found;
            r_out_ovf   <= i_cmd.out_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;
    assign o_out_found = r_out_found;
    assign o_out_ovf   = r_out_ovf;

endmodule

`default_nettype wire

@@ rtl/nlp_controller.sv @@
// ============================================================================
// nlp_controller
// State machine that loads the sequence, searches the pivot and, if found,
// the successor, swaps them, reverses the suffix and then reads it out.
// ============================================================================
`default_nettype none

module nlp_controller
    import nlp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    localparam int IW     = $clog2(MAX_LEN),
    localparam int CW     = $clog2(MAX_LEN + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_last,
    output logic               o_in_ready,
    input  wire t_status       i_status,
    output t_cmd               o_cmd,
    output logic [IW-1:0]      o_waddr,
    output logic [IW-1:0]      o_raddr
);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_P_RD  = 4'd1;
    localparam logic [3:0] S_P_CMP = 4'd2;
    localparam logic [3:0] S_Q_RD  = 4'd3;
    localparam logic [3:0] S_Q_CMP = 4'd4;
    localparam logic [3:0] S_SWAP  = 4'd5;
    localparam logic [3:0] S_R_CHK = 4'd6;
    localparam logic [3:0] S_R_RDA = 4'd7;
    localparam logic [3:0] S_R_RDB = 4'd8;
    localparam logic [3:0] S_R_WA  = 4'd9;
    localparam logic [3:0] S_R_WB  = 4'd10;
    localparam logic [3:0] S_E_RD  = 4'd11;
    localparam logic [3:0] S_E_LD  = 4'd12;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_found, n_found;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_p, n_p;
    logic [IW-1:0] r_lo, n_lo;
    logic [IW-1:0] r_hi, n_hi;
    logic [CW-1:0] last_cnt;
    logic [IW-1:0] last_ix;
    logic [CW-1:0] load_cnt;
    logic          has_room;
    logic          in_xfer;

    // Index of the last stored element.
    assign last_cnt = r_count - CW'(1);
    assign last_ix  = last_cnt[IW-1:0];
    assign has_room = r_count < CW'(MAX_LEN);
    assign load_cnt = has_room ? (r_count + CW'(1)) : r_count;
    assign in_xfer  = i_in_valid && (r_state == S_LOAD);

    assign o_in_ready = (r_state == S_LOAD);

    // Next-state and command logic.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_found = r_found;
        n_idx   = r_idx;
        n_p     = r_p;
        n_lo    = r_lo;
        n_hi    = r_hi;
        o_cmd   = '0;
        o_cmd.wsel      = WSEL_IN;
        o_cmd.out_last  = (r_idx == last_ix);
        o_cmd.out_found = r_found;
        o_cmd.out_ovf   = r_ovf;
        o_waddr = r_count[IW-1:0];
        o_raddr = r_idx;

        unique case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    if (has_room) begin
                        o_cmd.mem_we = 1'b1;
                        n_count      = load_cnt;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_last) begin
                        n_found = 1'b0;
                        if (load_cnt < CW'(2)) begin
                            n_idx   = '0;
                            n_state = S_E_RD;
                        end else begin
                            n_idx   = IW'(load_cnt - CW'(1));
                            n_state = S_P_RD;
                        end
                    end
                end
            end
            S_P_RD: begin
                o_raddr = r_idx;
                n_state = S_P_CMP;
            end
            S_P_CMP: begin
                // Walk right to left looking for the first ascent.
                if (r_idx == last_ix) begin
                    o_cmd.prev_ld = 1'b1;
                    n_idx         = r_idx - IW'(1);
                    n_state       = S_P_RD;
                end else if (i_status.lt_prev) begin
                    o_cmd.piv_ld = 1'b1;
                    n_p          = r_idx;
                    n_hi         = last_ix;
                    n_found      = 1'b1;
                    n_state      = S_Q_RD;
                end else if (r_idx == '0) begin
                    o_cmd.prev_ld = 1'b1;
                    n_state       = S_E_RD;
                end else begin
                    o_cmd.prev_ld = 1'b1;
                    n_idx         = r_idx - IW'(1);
                    n_state       = S_P_RD;
                end
            end
            S_Q_RD: begin
                o_raddr = r_hi;
                n_state = S_Q_CMP;
            end
            S_Q_CMP: begin
                // Rightmost element above the pivot; it always exists here.
                if (i_status.gt_piv) begin
                    o_cmd.hold_ld = 1'b1;
                    o_cmd.mem_we  = 1'b1;
                    o_cmd.wsel    = WSEL_PIV;
                    o_waddr       = r_hi;
                    n_state       = S_SWAP;
                end else begin
                    n_hi    = r_hi - IW'(1);
                    n_state = S_Q_RD;
                end
            end
            S_SWAP: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = WSEL_HOLD;
                o_waddr      = r_p;
                n_lo         = r_p + IW'(1);
                n_hi         = last_ix;
                n_state      = S_R_CHK;
            end
            S_R_CHK: begin
                if (r_lo < r_hi) begin
                    n_state = S_R_RDA;
                end else begin
                    n_idx   = '0;
                    n_state = S_E_RD;
                end
            end
            S_R_RDA: begin
                o_raddr = r_lo;
                n_state = S_R_RDB;
            end
            S_R_RDB: begin
                o_raddr       = r_hi;
                o_cmd.hold_ld = 1'b1;
                n_state       = S_R_WA;
            end
            S_R_WA: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = WSEL_RDATA;
                o_waddr      = r_lo;
                n_state      = S_R_WB;
            end
            S_R_WB: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = WSEL_HOLD;
                o_waddr      = r_hi;
                n_lo         = r_lo + IW'(1);
                n_hi         = r_hi - IW'(1);
                n_state      = S_R_CHK;
            end
            S_E_RD: begin
                o_raddr = r_idx;
                n_state = S_E_LD;
            end
            S_E_LD: begin
                // Hand one element to the output register when it has room.
                if (i_status.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    if (r_idx == last_ix) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_E_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_found <= n_found;
        end
    end

    // Index registers.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_p   <= n_p;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
    end

endmodule

`default_nettype wire

@@ rtl/next_lexicographic_permutation.sv @@
// ============================================================================
// next_lexicographic_permutation
// Loads a signed sequence, steps it to its next lexicographic permutation if
// one exists and streams the result back with found and overflow flags.
// ============================================================================
//
// Channel   Dir  tdata               tlast        tuser
// s_axis    in   [15:0] element      last element -
// m_axis    out  [15:0] result       end of run   [0] found, [1] overflow
//
// Loading takes one cycle per element; elements past MAX_LEN are dropped.
// After the last element the single read port of the store sets the pace:
// the pivot and successor searches read and then compare each element
// visited, the swap follows the successor compare, each suffix pair is read
// and written at both ends between checks, and readout reads each element out.
// Input is not ready from the last element until the final result is in
// the output register; a stalled master side holds the readout.
// Reset is synchronous and active low; the store itself is not cleared.
// ============================================================================
`default_nettype none

module next_lexicographic_permutation
    import nlp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [DATA_W-1:0] s_axis_tdata,   // [15:0] element_value
    input  wire logic              s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [DATA_W-1:0]      m_axis_tdata,   // [15:0] result_value
    output logic                   m_axis_tlast,
    output logic [1:0]             m_axis_tuser    // [0] found_next, [1] overflowed
);

    localparam int IW = $clog2(MAX_LEN);

    t_cmd          cmd;
    t_status       status;
    logic [IW-1:0] waddr;
    logic [IW-1:0] raddr;
    logic          out_found;
    logic          out_ovf;

    // Sequencing of load, search, permute and readout.
    nlp_controller #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_waddr    (waddr),
        .o_raddr    (raddr)
    );

    // Store, compares and output register.
    nlp_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_waddr     (waddr),
        .i_raddr     (raddr),
        .i_in_data   (s_axis_tdata),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_found (out_found),
        .o_out_ovf   (out_ovf)
    );

    // Result flags packed into the user field, lowest bit first.
    assign m_axis_tuser = {out_ovf, out_found};

endmodule

`default_nettype wire

@@ rtl/nlp_checker.sv @@
// ============================================================================
// nlp_port_checker
// Port-level checks on the permutation engine, attached by bind.
// ============================================================================
`default_nettype none

module nlp_port_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [15:0] s_axis_tdata,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic [1:0]  m_axis_tuser
);

    logic       r_mid;
    logic [1:0] r_user;
    logic       s_xfer;
    logic       m_xfer;

    assign s_xfer = s_axis_tvalid && s_axis_tready;
    assign m_xfer = m_axis_tvalid && m_axis_tready;

    // Track whether a run is partly delivered and its flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid  <= 1'b0;
            r_user <= '0;
        end else if (m_xfer) begin
            r_mid  <= !m_axis_tlast;
            r_user <= m_axis_tuser;
        end
    end

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output payload changed under stall");

    // Found and overflow flags stay constant across one run.
    a_flags_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_xfer && r_mid |-> m_axis_tuser == r_user)
        else $error("run flags changed within a run");

    // New input is taken only when no unfinished run is in the output stage.
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !(m_axis_tvalid && !m_axis_tlast))
        else $error("input ready while a run is still streaming");

    // The last element closes the input side for the computation.
    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready right after the last element");

    // Reset empties the output stage.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind next_lexicographic_permutation nlp_port_checker u_nlp_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/nlp_checker.sv @@
// ============================================================================
// nlp_checker
// Watches both stream channels of the next-permutation engine. It mirrors the
// element store from the input transactions and predicts each emitted
// sequence. Every output transaction is compared with the oldest prediction.
// ============================================================================
`default_nettype none

module nlp_checker
    import nlp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    input  wire logic              s_axis_tready,
    input  wire logic [DATA_W-1:0] s_axis_tdata,   // [15:0] element_value
    input  wire logic              s_axis_tlast,
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [DATA_W-1:0] m_axis_tdata,   // [15:0] result_value
    input  wire logic              m_axis_tlast,
    input  wire logic [1:0]        m_axis_tuser,   // [0] found_next, [1] overflowed
    output int                     o_fail_count,
    output int                     o_outstanding,
    output int                     o_runs,
    output int                     o_ovf_runs,
    output int                     o_final_runs,
    output int                     o_results
);

    timeunit 1ns;
    timeprecision 1ps;

    // One emitted element with its flags.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     end_of_run;
        logic                     found;
        logic                     ovf;
    } t_perm_elem;

    // Predicted output transactions, oldest first.
    t_perm_elem expected_elems[$];

    // Local copy of the sequence being loaded.
    logic signed [DATA_W-1:0] seq_store [MAX_LEN];
    int                       seq_len;
    logic                     seq_ovf;

    int fail_count;
    int runs;
    int ovf_runs;
    int final_runs;
    int results;

    // Steps the first n stored elements to their next permutation in place.
    // Returns 0 and leaves the store untouched when none exists.
    function automatic logic advance_sequence(input int n);
        int                       pivot;
        int                       succ;
        int                       lo;
        int                       hi;
        int                       k;
        logic signed [DATA_W-1:0] tmp;
        pivot = -1;
        for (k = n - 2; k >= 0; k--) begin
            if (pivot < 0 && seq_store[k] < seq_store[k + 1]) begin
                pivot = k;
            end
        end
        if (pivot < 0) begin
            return 1'b0;
        end
        // The element right of the pivot is larger, so this search stops.
        succ = n - 1;
        while (!(seq_store[succ] > seq_store[pivot])) begin
            succ--;
        end
        tmp              = seq_store[pivot];
        seq_store[pivot] = seq_store[succ];
        seq_store[succ]  = tmp;
        lo = pivot + 1;
        hi = n - 1;
        while (lo < hi) begin
            tmp           = seq_store[lo];
            seq_store[lo] = seq_store[hi];
            seq_store[hi] = tmp;
            lo++;
            hi--;
        end
        return 1'b1;
    endfunction

    // Outputs are checked before inputs are absorbed, so a new prediction
    // can never hide an unexpected result in the same cycle.
    always @(posedge i_clk) begin
        t_perm_elem got;
        t_perm_elem want;
        logic       found;
        int         i;
        if (!i_rst_n) begin
            expected_elems.delete();
            seq_len    = 0;
            seq_ovf    = 1'b0;
            fail_count = 0;
            runs       = 0;
            ovf_runs   = 0;
            final_runs = 0;
            results    = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.value      = m_axis_tdata;
                got.end_of_run = m_axis_tlast;
                got.found      = m_axis_tuser[0];
                got.ovf        = m_axis_tuser[1];
                results++;
                if (expected_elems.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("ERROR: unexpected result value %0d last %b found %b ovf %b",
                                 got.value, got.end_of_run, got.found, got.ovf);
                    end
                    fail_count++;
                end else begin
                    want = expected_elems.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10) begin
                            $display({"ERROR: result %0d expected value %0d last %b found %b",
                                      " ovf %b, got value %0d last %b found %b ovf %b"},
                                     results, want.value, want.end_of_run, want.found,
                                     want.ovf, got.value, got.end_of_run, got.found, got.ovf);
                        end
                        fail_count++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                // A full store drops the element, the last one included.
                if (seq_len < MAX_LEN) begin
                    seq_store[seq_len] = s_axis_tdata;
                    seq_len++;
                end else begin
                    seq_ovf = 1'b1;
                end
                if (s_axis_tlast) begin
                    found = advance_sequence(seq_len);
                    for (i = 0; i < seq_len; i++) begin
                        want.value      = seq_store[i];
                        want.end_of_run = (i == seq_len - 1);
                        want.found      = found;
                        want.ovf        = seq_ovf;
                        expected_elems.push_back(want);
                    end
                    runs++;
                    if (seq_ovf) begin
                        ovf_runs++;
                    end
                    if (!found) begin
                        final_runs++;
                    end
                    seq_len = 0;
                    seq_ovf = 1'b0;
                end
            end
        end

        // Published with nonblocking updates so readers see a stable value.
        o_fail_count  <= fail_count;
        o_outstanding <= expected_elems.size();
        o_runs        <= runs;
        o_ovf_runs    <= ovf_runs;
        o_final_runs  <= final_runs;
        o_results     <= results;
    end

endmodule

`default_nettype wire

@@ tb/tb_next_lexicographic_permutation.sv @@
// ============================================================================
// tb_next_lexicographic_permutation
// Streams sequences into the next-permutation engine with random idles on
// both channels: a directed set of corner sequences first, then random
// sequences of mostly short lengths with occasional full and overflowing
// ones. A separate checker predicts and compares; this module gives the
// verdict.
// ============================================================================
`default_nettype none

module tb_next_lexicographic_permutation
    import nlp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tready = 1'b0;
    logic              s_axis_tready;
    logic              m_axis_tvalid;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;
    logic [1:0]        m_axis_tuser;

    int fail_count;
    int outstanding;
    int runs;
    int ovf_runs;
    int final_runs;
    int results;

    // Idle chances in percent for the sender and the receiver.
    int src_idle_pct  = 29;
    int sink_idle_pct = 45;
    int items_sent    = 0;

    always #5 i_clk = ~i_clk;

    next_lexicographic_permutation #(
        .MAX_LEN(MAX_LEN_DEF)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    nlp_checker #(
        .MAX_LEN(MAX_LEN_DEF)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding),
        .o_runs       (runs),
        .o_ovf_runs   (ovf_runs),
        .o_final_runs (final_runs),
        .o_results    (results)
    );

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Offers one element and returns at the edge where it is taken.
    task automatic send_element(input logic [DATA_W-1:0] value, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_sequence(input logic [DATA_W-1:0] elems[$]);
        int k;
        for (k = 0; k < elems.size(); k++) begin
            send_element(elems[k], k == elems.size() - 1);
        end
    endtask

    // Holds the sender off until every predicted result has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin
        logic [DATA_W-1:0] seq[$];
        int                len;
        int                mode;
        int                prev;
        int                k;
        int                pick;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a single element, both orders of the extremes, an
        // alternating bit pattern with a repeated value, and a store overflow
        // where the element flagged last is dropped.
        seq = '{16'h7FFF};
        send_sequence(seq);
        seq = '{16'h8000, 16'h7FFF};
        send_sequence(seq);
        seq = '{16'h7FFF, 16'h8000};
        send_sequence(seq);
        seq = '{16'h5555, 16'hAAAA, 16'h5555};
        send_sequence(seq);
        seq.delete();
        for (k = 0; k < MAX_LEN_DEF + 1; k++) begin
            seq.push_back(DATA_W'(k % 5));
        end
        send_sequence(seq);

        // Random sequences, in three idle phases.
        while (items_sent < 180) begin
            if (items_sent >= 80 && src_idle_pct == 29) begin
                drain_results();
                src_idle_pct = 45;
                sink_idle_pct <= 29;
            end else if (items_sent >= 130 && src_idle_pct == 45) begin
                drain_results();
                src_idle_pct = 0;
                sink_idle_pct <= 0;
            end

            pick = $urandom_range(99);
            if (pick < 8) begin
                len = 1;
            end else if (pick < 78) begin
                len = $urandom_range(2, 6);
            end else if (pick < 90) begin
                len = $urandom_range(7, MAX_LEN_DEF);
            end else begin
                len = $urandom_range(MAX_LEN_DEF + 1, MAX_LEN_DEF + 4);
            end

            // Narrow values give repeats and many pivots, full-range values
            // toggle every bit, and non-increasing runs are last permutations.
            mode = $urandom_range(2);
            prev = $urandom_range(0, 65535) - 32768;
            seq.delete();
            for (k = 0; k < len; k++) begin
                if (mode == 0) begin
                    seq.push_back(DATA_W'($urandom_range(0, 4) - 2));
                end else if (mode == 1) begin
                    seq.push_back(DATA_W'($urandom_range(0, 65535)));
                end else begin
                    prev = prev - $urandom_range(0, 3);
                    if (prev < -32768) begin
                        prev = -32768;
                    end
                    seq.push_back(DATA_W'(prev));
                end
            end
            send_sequence(seq);
        end

        drain_results();
        repeat (64) @(posedge i_clk);

        $display("Sent %0d elements in %0d sequences: %0d overflowed the store,",
                 items_sent, runs, ovf_runs);
        $display("%0d had no successor; compared %0d output elements, %0d left unmatched.",
                 final_runs, results, outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2_000_000ns;
        $display("Run did not complete in time.");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/nlp_pkg.sv
rtl/nlp_datapath.sv
rtl/nlp_controller.sv
rtl/next_lexicographic_permutation.sv
rtl/nlp_checker.sv
tb/nlp_checker.sv
tb/tb_next_lexicographic_permutation.sv
